/* rtl/qrte_pkg.sv */
// ----------------------------------------------------------------------------
// qrte_pkg
// Shared sizes, codes and types of the Q-routing table engine.
// ----------------------------------------------------------------------------
package qrte_pkg;

    localparam int NODE_COUNT = 16;
    localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int LINK_COUNT = NODE_COUNT * NODE_COUNT;
    localparam int LINK_W     = $clog2(LINK_COUNT);

    localparam int Q_W     = 16;
    localparam int CNTR_W  = 32;
    localparam int ALPHA_W = 9;

    localparam logic [Q_W-1:0]     Q_MAX       = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
    localparam logic [3:0]         SINK_RESET  = 4'd0;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_NODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'b1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FORWARD = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED    = 2'd0,
        ST_FORWARDED = 2'd1,
        ST_AT_SINK   = 2'd2,
        ST_NO_ROUTE  = 2'd3
    } t_status;

    // one request into the min-search unit
    typedef struct packed {
        logic              clear;
        logic              en;
        logic              vld;
        logic [Q_W-1:0]    q;
        logic [NODE_W-1:0] idx;
    } t_scan_req;

    typedef struct packed {
        logic              found;
        logic [Q_W-1:0]    q;
        logic [NODE_W-1:0] idx;
    } t_scan_res;

    function automatic logic [LINK_W-1:0] link_addr(input logic [NODE_W-1:0] row,
                                                    input logic [NODE_W-1:0] col);
        logic [LINK_W+NODE_W:0] full;
        full = (LINK_W+NODE_W+1)'(row) * (LINK_W+NODE_W+1)'(NODE_COUNT)
             + (LINK_W+NODE_W+1)'(col);
        return full[LINK_W-1:0];
    endfunction

endpackage

/* rtl/qrte_ram.sv */
// ----------------------------------------------------------------------------
// qrte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qrte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/qrte_minscan.sv */
// ----------------------------------------------------------------------------
// qrte_minscan
// Running minimum over a streamed table row; first (lowest id) wins ties.
// ----------------------------------------------------------------------------
module qrte_minscan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qrte_pkg::t_scan_req i_req,
    output qrte_pkg::t_scan_res o_res
);
    import qrte_pkg::*;

    logic              r_found;
    logic [Q_W-1:0]    r_q;
    logic [NODE_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_req.clear) begin
            r_found <= 1'b0;
        end else if (i_req.en && i_req.vld && (!r_found || i_req.q < r_q)) begin
            r_found <= 1'b1;
        end
        if (!i_req.clear && i_req.en && i_req.vld && (!r_found || i_req.q < r_q)) begin
            r_q   <= i_req.q;
            r_idx <= i_req.idx;
        end
    end

    assign o_res.found = r_found;
    assign o_res.q     = r_q;
    assign o_res.idx   = r_idx;

endmodule

/* rtl/qrte_update.sv */
// ----------------------------------------------------------------------------
// qrte_update
// Two-stage estimate update: Q + round(alpha * (cost + future - Q)), clamped.
// ----------------------------------------------------------------------------
module qrte_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [qrte_pkg::ALPHA_W-1:0]  i_alpha,
    input  logic [qrte_pkg::Q_W-1:0]      i_q,
    input  logic [qrte_pkg::Q_W-1:0]      i_cost,
    input  logic [qrte_pkg::Q_W-1:0]      i_future,
    output logic                          o_done,
    output logic [qrte_pkg::Q_W-1:0]      o_result
);
    import qrte_pkg::*;

    localparam int DIFF_W = Q_W + 2;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;

    logic [ALPHA_W-1:0]       alpha_c;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] delta;
    logic signed [PROD_W-1:0] sum;

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]           r_q1;
    logic                     r_done;
    logic [Q_W-1:0]           r_result;

    always_comb begin
        alpha_c = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
        diff    = $signed({2'b00, i_cost}) + $signed({2'b00, i_future})
                - $signed({2'b00, i_q});
        prod    = PROD_W'($signed({1'b0, alpha_c}) * diff);
        rounded = r_prod + PROD_W'(128);
        delta   = rounded >>> 8;            // floor division by 256
        sum     = $signed(PROD_W'(r_q1)) + delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_go;
            r_done <= r_v1;
        end
        r_prod <= prod;
        r_q1   <= i_q;
        if (sum < 0) begin
            r_result <= '0;
        end else if (sum > $signed(PROD_W'(Q_MAX))) begin
            r_result <= Q_MAX;
        end else begin
            r_result <= sum[Q_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/q_routing_table_engine.sv */
// ----------------------------------------------------------------------------
// q_routing_table_engine
// Q-routing link table: loads link estimates, forwards one hop by picking the
// cheapest valid link and updating its estimate toward cost + future.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                                       Handshake
// config    in         i_cfg_we i_cfg_addr i_cfg_wdata             write on i_cfg_we
// request   in         i_opcode i_node i_neighbour i_link_cost     start & !busy
// result    out        o_status o_next_hop o_new_estimate          o_valid, one cycle
//                      o_sent_count o_received_count
//
// Load: busy stays low, result one cycle after the request.
// Forward at the sink or from an unknown node: busy stays low, result next cycle.
// Forward with no valid link: NODE_COUNT+2 busy cycles (one row scan).
// Forward: 2*NODE_COUNT+7 busy cycles, or NODE_COUNT+6 when the next hop is the
// sink; set by the two row scans through the estimate RAM read port.
// Reset clears valid marks and counters at once; results cannot be stalled.
// ----------------------------------------------------------------------------
module q_routing_table_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qrte_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [qrte_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [3:0]                        i_node,
    input  logic [3:0]                        i_neighbour,
    input  logic [15:0]                       i_link_cost,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [3:0]                        o_next_hop,
    output logic [15:0]                       o_new_estimate,
    output logic [31:0]                       o_sent_count,
    output logic [31:0]                       o_received_count
);
    import qrte_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_PICK,
        S_SCAN2,
        S_READ,
        S_WAIT,
        S_MUL
    } t_state;

    t_state              r_state;
    logic [3:0]          r_sink;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [LINK_COUNT-1:0] r_link_valid;
    logic [CNTR_W-1:0]   r_sent [NODE_COUNT];
    logic [CNTR_W-1:0]   r_recv [NODE_COUNT];
    logic [CNT_W-1:0]    r_cnt;
    logic [NODE_W-1:0]   r_row;
    logic [NODE_W-1:0]   r_node;
    logic [NODE_W-1:0]   r_best;
    logic                r_to_sink;
    logic [Q_W-1:0]      r_future;

    logic                r_valid;
    t_status             r_status;
    logic [3:0]          r_next_hop;
    logic [Q_W-1:0]      r_new_est;
    logic [CNTR_W-1:0]   r_sent_out;
    logic [CNTR_W-1:0]   r_recv_out;

    logic                accept;
    logic                node_ok;
    logic                nb_ok;
    logic [NODE_W-1:0]   in_node;
    logic [NODE_W-1:0]   in_nb;
    logic                scanning;
    logic [NODE_W-1:0]   prev_col;
    logic [LINK_W-1:0]   sel_link;

    logic                est_we;
    logic [LINK_W-1:0]   est_waddr;
    logic [Q_W-1:0]      est_wdata;
    logic                etx_we;
    logic [LINK_W-1:0]   raddr;
    logic [Q_W-1:0]      est_rdata;
    logic [Q_W-1:0]      etx_rdata;

    t_scan_req           scan_req;
    t_scan_res           scan_res;

    logic                upd_go;
    logic                upd_done;
    logic [Q_W-1:0]      upd_result;
    logic [CNTR_W-1:0]   n_sent;
    logic [CNTR_W-1:0]   n_recv;

    always_comb begin
        accept   = start && !busy;
        node_ok  = 32'(i_node) < NODE_COUNT;
        nb_ok    = 32'(i_neighbour) < NODE_COUNT;
        in_node  = NODE_W'(i_node);
        in_nb    = NODE_W'(i_neighbour);
        scanning = (r_state == S_SCAN1) || (r_state == S_SCAN2);
        prev_col = NODE_W'(r_cnt - CNT_W'(1));
        sel_link = link_addr(r_node, r_best);

        // loads write at request time; the forward writes back its update
        if (r_state == S_MUL) begin
            est_we    = upd_done;
            est_waddr = sel_link;
            est_wdata = upd_result;
        end else begin
            est_we    = accept && (i_opcode == OP_LOAD) && node_ok && nb_ok;
            est_waddr = link_addr(in_node, in_nb);
            est_wdata = i_link_cost;
        end
        etx_we = accept && (i_opcode == OP_LOAD) && node_ok && nb_ok;

        raddr = scanning ? link_addr(r_row, NODE_W'(r_cnt)) : sel_link;

        scan_req.clear = scanning && (r_cnt == '0);
        scan_req.en    = scanning && (r_cnt != '0);
        scan_req.vld   = r_link_valid[link_addr(r_row, prev_col)];
        scan_req.q     = est_rdata;
        scan_req.idx   = prev_col;

        upd_go = (r_state == S_WAIT);
        n_sent = r_sent[r_node] + CNTR_W'(1);
        n_recv = r_recv[r_best] + CNTR_W'(1);
    end

    qrte_ram #(.WIDTH(Q_W), .DEPTH(LINK_COUNT)) u_est_ram (
        .i_clk   (i_clk),
        .i_we    (est_we),
        .i_waddr (est_waddr),
        .i_wdata (est_wdata),
        .i_raddr (raddr),
        .o_rdata (est_rdata)
    );

    qrte_ram #(.WIDTH(Q_W), .DEPTH(LINK_COUNT)) u_etx_ram (
        .i_clk   (i_clk),
        .i_we    (etx_we),
        .i_waddr (link_addr(in_node, in_nb)),
        .i_wdata (i_link_cost),
        .i_raddr (raddr),
        .o_rdata (etx_rdata)
    );

    qrte_minscan u_minscan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .o_res   (scan_res)
    );

    qrte_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (upd_go),
        .i_alpha  (r_alpha),
        .i_q      (est_rdata),
        .i_cost   (etx_rdata),
        .i_future (r_future),
        .o_done   (upd_done),
        .o_result (upd_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sink       <= SINK_RESET;
            r_alpha      <= ALPHA_RESET;
            r_link_valid <= '0;
            r_valid      <= 1'b0;
            r_cnt        <= '0;
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_sent[i] <= '0;
                r_recv[i] <= '0;
            end
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_SINK_NODE:     r_sink  <= i_cfg_wdata[3:0];
                    CFG_LEARNING_RATE: r_alpha <= i_cfg_wdata[ALPHA_W-1:0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_opcode == OP_LOAD) begin
                            if (node_ok && nb_ok) begin
                                r_link_valid[link_addr(in_node, in_nb)] <= 1'b1;
                            end
                            r_valid    <= 1'b1;
                            r_status   <= ST_LOADED;
                            r_next_hop <= '0;
                            r_new_est  <= i_link_cost;
                            r_sent_out <= '0;
                            r_recv_out <= '0;
                        end else if (i_node == r_sink || !node_ok) begin
                            r_valid    <= 1'b1;
                            r_status   <= (i_node == r_sink) ? ST_AT_SINK : ST_NO_ROUTE;
                            r_next_hop <= '0;
                            r_new_est  <= '0;
                            r_sent_out <= '0;
                            r_recv_out <= '0;
                        end else begin
                            r_node  <= in_node;
                            r_row   <= in_node;
                            r_cnt   <= '0;
                            r_state <= S_SCAN1;
                        end
                    end
                end
                S_SCAN1, S_SCAN2: begin
                    // read data trails the address, as the RAM registers it
                    if (32'(r_cnt) == NODE_COUNT) begin
                        r_state <= (r_state == S_SCAN1) ? S_PICK : S_READ;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_PICK: begin
                    if (!scan_res.found) begin
                        r_valid    <= 1'b1;
                        r_status   <= ST_NO_ROUTE;
                        r_next_hop <= '0;
                        r_new_est  <= '0;
                        r_sent_out <= '0;
                        r_recv_out <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_best    <= scan_res.idx;
                        r_to_sink <= 8'(scan_res.idx) == 8'(r_sink);
                        r_row     <= scan_res.idx;
                        r_cnt     <= '0;
                        r_state   <= (8'(scan_res.idx) == 8'(r_sink)) ? S_READ : S_SCAN2;
                    end
                end
                S_READ: begin
                    // next hop with no valid link counts as saturated cost
                    if (r_to_sink) begin
                        r_future <= '0;
                    end else begin
                        r_future <= scan_res.found ? scan_res.q : Q_MAX;
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (upd_done) begin
                        r_sent[r_node] <= n_sent;
                        r_recv[r_best] <= n_recv;
                        r_valid    <= 1'b1;
                        r_status   <= ST_FORWARDED;
                        r_next_hop <= 4'(r_best);
                        r_new_est  <= upd_result;
                        r_sent_out <= n_sent;
                        r_recv_out <= n_recv;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_next_hop       = r_next_hop;
    assign o_new_estimate   = r_new_est;
    assign o_sent_count     = r_sent_out;
    assign o_received_count = r_recv_out;

endmodule
